>>> design/rpah_pkg.sv
// ----------------------------------------------------------------------------
// rpah_pkg
// Shared types, constants and table builders for the RSSI averager.
// ----------------------------------------------------------------------------
package rpah_pkg;

	localparam int CHANNELS_DEF      = 79;
	localparam int AVG_DEPTH_DEF     = 10;
	localparam int HISTORY_DEPTH_DEF = 10;

	localparam int LEVEL_FLOOR = 137;
	localparam int TAB_SIZE    = LEVEL_FLOOR + 1;
	localparam int LIN_W       = 61;
	localparam int SUM_W       = 64;
	localparam int THR_W       = 66;
	localparam int LEVEL_W     = 9;
	localparam int CH_W        = 7;
	localparam int DBM_W       = 8;
	localparam int IDX_W       = 8;

	localparam logic REQ_UPDATE  = 1'b0;
	localparam logic REQ_DISPLAY = 1'b1;

	localparam logic signed [LEVEL_W-1:0] EMPTY_LEVEL  = -9'sd127;
	localparam logic [CH_W-1:0]           SAMPLE_FLOOR = 7'd127;

	typedef logic [LIN_W-1:0] lin_tab_t [TAB_SIZE];
	typedef logic [THR_W-1:0] thr_tab_t [TAB_SIZE];

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_SEARCH,
		ST_SNAP,
		ST_FIN
	} state_t;

	// round(10^(-r/10) * 2^32)
	function automatic logic [32:0] frac_of(input int r);
		logic [32:0] f;
		case (r)
			0: f = 33'd4294967296;
			1: f = 33'd3411613790;
			2: f = 33'd2709941160;
			3: f = 33'd2152582778;
			4: f = 33'd1709857278;
			5: f = 33'd1358187910;
			6: f = 33'd1078847008;
			7: f = 33'd856958639;
			8: f = 33'd680706442;
			default: f = 33'd540704347;
		endcase
		return f;
	endfunction

	// Linear power for k = -dBm, 0 dBm scaled to 2^60.
	function automatic lin_tab_t build_lin();
		lin_tab_t t;
		logic [63:0] base;
		logic [127:0] hi_p;
		logic [127:0] lo_p;
		logic [32:0] f;
		for (int k = 0; k < TAB_SIZE; k++) begin
			base = 64'd1 << 60;
			for (int i = 0; i < k / 10; i++) begin
				base = base / 64'd10;
			end
			f = frac_of(k % 10);
			hi_p = {96'd0, base[63:32]} * {95'd0, f};
			lo_p = ({96'd0, base[31:0]} * {95'd0, f}) >> 32;
			t[k] = LIN_W'(hi_p + lo_p);
		end
		return t;
	endfunction

	// A mean floor(sum/depth) is at most P[k] exactly when sum < (P[k]+1)*depth.
	function automatic thr_tab_t build_thr(input int depth);
		thr_tab_t t;
		lin_tab_t lin;
		logic [127:0] p;
		lin = build_lin();
		for (int k = 0; k < TAB_SIZE; k++) begin
			p = ({67'd0, lin[k]} + 128'd1) * 128'(depth);
			t[k] = THR_W'(p);
		end
		return t;
	endfunction

endpackage

>>> design/rpah_if.sv
// ----------------------------------------------------------------------------
// rpah_if
// Request and response channels of the RSSI averager.
// ----------------------------------------------------------------------------
interface rpah_req_if;
	import rpah_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [CH_W-1:0]         channel;
	logic signed [DBM_W-1:0] sample_dbm;

	modport source (output valid, req_type, channel, sample_dbm, input ready);
	modport sink (input valid, req_type, channel, sample_dbm, output ready);
endinterface

interface rpah_rsp_if;
	import rpah_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CH_W-1:0]           out_channel;
	logic signed [LEVEL_W-1:0] level_dbm;

	modport source (output valid, out_channel, level_dbm, input ready);
	modport sink (input valid, out_channel, level_dbm, output ready);
endinterface

>>> design/rpah_ram.sv
// ----------------------------------------------------------------------------
// rpah_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpah_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/rssi_power_average_history.sv
// Update path: RAM read at the request transfer, one sum update, eight binary-search steps
// over the dB threshold table, one history write, one output load; a display goes from the
// read straight to the output load. The output load waits until the output register is free.
// Flow: one item at a time; the next request is taken the cycle after the result is loaded
// into the output register.
// Reset: a clearing pass writes zero to CHANNELS*AVG_DEPTH sample entries (and the
// sums), one per cycle, before the first request is accepted.
// ----------------------------------------------------------------------------
// rssi_power_average_history
// Per-channel ring average of linear RSSI power with a frame history.
// ----------------------------------------------------------------------------
module rssi_power_average_history #(
	parameter int CHANNELS      = rpah_pkg::CHANNELS_DEF,
	parameter int AVG_DEPTH     = rpah_pkg::AVG_DEPTH_DEF,
	parameter int HISTORY_DEPTH = rpah_pkg::HISTORY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rpah_req_if.sink   req,
	rpah_rsp_if.source rsp
);
	import rpah_pkg::*;

	localparam int AD_W   = AVG_DEPTH > 1 ? $clog2(AVG_DEPTH) : 1;
	localparam int HS_W   = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CI_W   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int HA_N   = CHANNELS * AVG_DEPTH;
	localparam int HA_W   = HA_N > 1 ? $clog2(HA_N) : 1;
	localparam int SA_N   = CHANNELS * HISTORY_DEPTH;
	localparam int SA_W   = SA_N > 1 ? $clog2(SA_N) : 1;
	localparam int CLR_W  = $clog2(HA_N + 1);

	localparam lin_tab_t LIN = build_lin();
	localparam thr_tab_t THR = build_thr(AVG_DEPTH);

	state_t state_q, state_d;

	logic                      req_q;
	logic [CH_W-1:0]           ch_q;
	logic                      ok_q;
	logic [CH_W-1:0]           k_q;
	logic [HA_W-1:0]           hist_addr_q;
	logic [SUM_W:0]            sum_q;
	logic [IDX_W-1:0]          best_q;
	logic [2:0]                bit_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic [AD_W-1:0]           avg_slot_q;
	logic [HS_W-1:0]           write_slot_q;
	logic [FILL_W-1:0]         filled_q;
	logic [CLR_W-1:0]          clr_q;
	logic                      rsp_valid_q;
	logic [CH_W-1:0]           rsp_ch_q;
	logic signed [LEVEL_W-1:0] rsp_level_q;

	logic                      accept;
	logic                      load_out;
	logic                      commit;
	logic [CH_W-1:0]           k_in;
	logic [HS_W-1:0]           newest_slot;
	logic [HA_W-1:0]           hist_raddr;
	logic [SA_W-1:0]           snap_raddr;
	logic [SA_W-1:0]           snap_waddr;
	logic [LIN_W-1:0]          fresh;
	logic [SUM_W-1:0]          sum_new;
	logic [IDX_W-1:0]          cand;
	logic [IDX_W-1:0]          cand_idx;
	logic                      take;
	logic signed [LEVEL_W-1:0] level_upd;
	logic signed [LEVEL_W-1:0] level_disp;

	logic                      hist_we, sum_we, snap_we;
	logic [HA_W-1:0]           hist_waddr;
	logic [CI_W-1:0]           sum_waddr;
	logic [LIN_W-1:0]          hist_wdata;
	logic [SUM_W-1:0]          sum_wdata;
	logic [LIN_W-1:0]          hist_rdata;
	logic [SUM_W-1:0]          sum_rdata;
	logic [LEVEL_W-1:0]        snap_rdata;

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);
	assign commit   = (state_q == ST_SNAP) && (ch_q == CH_W'(CHANNELS - 1));

	// Samples above 0 dBm map to k = 0, below the floor to the floor.
	always_comb begin
		if (!req.sample_dbm[DBM_W-1]) begin
			k_in = '0;
		end else if (req.sample_dbm == -8'sd128) begin
			k_in = SAMPLE_FLOOR;
		end else begin
			k_in = CH_W'(-req.sample_dbm);
		end
	end

	assign newest_slot = (write_slot_q == '0) ? HS_W'(HISTORY_DEPTH - 1) : write_slot_q - 1'b1;
	assign hist_raddr  = HA_W'(int'(req.channel) * AVG_DEPTH + int'(avg_slot_q));
	assign snap_raddr  = SA_W'(int'(req.channel) * HISTORY_DEPTH + int'(newest_slot));
	assign snap_waddr  = SA_W'(int'(ch_q) * HISTORY_DEPTH + int'(write_slot_q));

	assign fresh   = LIN[{1'b0, k_q}];
	assign sum_new = sum_rdata - {3'b000, hist_rdata} + {3'b000, fresh};

	assign cand     = best_q | (IDX_W'(1) << bit_q);
	assign cand_idx = (cand <= IDX_W'(LEVEL_FLOOR)) ? cand : '0;
	assign take     = (cand <= IDX_W'(LEVEL_FLOOR)) && ({1'b0, sum_q} < THR[cand_idx]);

	assign level_upd  = -$signed({1'b0, best_q});
	assign level_disp = (ok_q && (filled_q != '0) && (snap_rdata != '0)) ?
		$signed(snap_rdata) : EMPTY_LEVEL;

	always_comb begin
		state_d    = state_q;
		hist_we    = 1'b0;
		sum_we     = 1'b0;
		snap_we    = 1'b0;
		hist_waddr = hist_addr_q;
		sum_waddr  = CI_W'(ch_q);
		hist_wdata = fresh;
		sum_wdata  = sum_new;
		req.ready  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				hist_we    = 1'b1;
				hist_waddr = HA_W'(clr_q);
				hist_wdata = '0;
				sum_we     = (clr_q < CLR_W'(CHANNELS));
				sum_waddr  = CI_W'(clr_q);
				sum_wdata  = '0;
				if (clr_q == CLR_W'(HA_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (req_q == REQ_UPDATE && ok_q) begin
					hist_we = 1'b1;
					sum_we  = 1'b1;
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SEARCH: begin
				if (bit_q == '0) begin
					state_d = ST_SNAP;
				end
			end
			ST_SNAP: begin
				snap_we = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			avg_slot_q   <= '0;
			write_slot_q <= '0;
			filled_q     <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (commit) begin
				write_slot_q <= (write_slot_q == HS_W'(HISTORY_DEPTH - 1)) ?
					'0 : write_slot_q + 1'b1;
				avg_slot_q <= (avg_slot_q == AD_W'(AVG_DEPTH - 1)) ? '0 : avg_slot_q + 1'b1;
				if (filled_q < FILL_W'(HISTORY_DEPTH)) begin
					filled_q <= filled_q + 1'b1;
				end
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q       <= req.req_type;
			ch_q        <= req.channel;
			ok_q        <= (int'(req.channel) < CHANNELS);
			k_q         <= k_in;
			hist_addr_q <= hist_raddr;
		end
		case (state_q)
			ST_CALC: begin
				sum_q   <= {sum_new == '0, sum_new};
				best_q  <= '0;
				bit_q   <= 3'd7;
				level_q <= (req_q == REQ_DISPLAY) ? level_disp : EMPTY_LEVEL;
			end
			ST_SEARCH: begin
				if (take) begin
					best_q <= cand;
				end
				bit_q <= bit_q - 1'b1;
			end
			ST_SNAP: begin
				level_q <= level_upd;
			end
			default: ;
		endcase
		if (load_out) begin
			rsp_ch_q    <= ch_q;
			rsp_level_q <= level_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_channel = rsp_ch_q;
	assign rsp.level_dbm   = rsp_level_q;

	rpah_ram #(.WIDTH(LIN_W), .DEPTH(HA_N)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	rpah_ram #(.WIDTH(SUM_W), .DEPTH(CHANNELS)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (CI_W'(req.channel)),
		.rdata (sum_rdata)
	);

	rpah_ram #(.WIDTH(LEVEL_W), .DEPTH(SA_N)) u_snap_ram (
		.clk   (clk),
		.we    (snap_we),
		.waddr (snap_waddr),
		.wdata (level_upd),
		.raddr (snap_raddr),
		.rdata (snap_rdata)
	);

`ifndef SYNTHESIS
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request taken during clearing pass");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(HISTORY_DEPTH))
		else $error("history fill count out of range");
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(write_slot_q < HS_W'(HISTORY_DEPTH)) && (avg_slot_q < AD_W'(AVG_DEPTH)))
		else $error("ring slot out of range");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> rsp.valid)
		else $error("loaded result not presented");
	a_search_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC && state_d == ST_SEARCH) |=> ##7 (state_q == ST_SEARCH && bit_q == '0))
		else $error("threshold search length wrong");
`endif
endmodule
